// ===== design/mbedc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbedc_pkg - shared types and constants of the escape-depth classifier
// Fixed-point format, counter widths, register indexes and the bundles that
// travel between the sequencer, the register block and the top level.
// ----------------------------------------------------------------------------
package mbedc_pkg;

	// fixed point: signed Q4.28 inputs
	localparam int FRAC_BITS = 28;
	localparam int DATA_W    = 32;
	// orbit values: one step past radius 2 plus c needs two more bits
	localparam int Z_W       = DATA_W + 2;

	// shared multiplier
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// step counting
	localparam int MAX_ITER  = 1000000;
	localparam int ITER_W    = $clog2(MAX_ITER + 1);
	localparam int DEPTH_W   = 20;
	localparam int CMP_W     = (ITER_W > DEPTH_W) ? ITER_W : DEPTH_W;

	// squared-distance limit of the cycle check, 1e-16 in Q.(2*FRAC_BITS)
	localparam logic [63:0] CYC_LIMIT =
		((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10000000000000000;

	// configuration port
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_HI  = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0] MIN_DEPTH_RST = CFG_W'(10000);
	localparam logic [CFG_W-1:0] DEPTH_HI_RST  = CFG_W'(100000);

	// stream widths
	localparam int IN_TDATA_W  = 4 * DATA_W;
	localparam int OUT_TDATA_W = ((DEPTH_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	typedef struct packed {
		logic [CFG_W-1:0] min_depth;
		logic [CFG_W-1:0] depth_hi;
	} cfg_t;

	typedef struct packed {
		logic               escaped;
		logic [DEPTH_W-1:0] depth;
		logic               in_window;
	} res_t;

endpackage

// ===== design/mandelbrot_escape_depth_classifier_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_depth_classifier_core - escape-depth classifier
// Takes a point c and a start value z, rejects the main cardioid and the
// period-2 bulb, then iterates z*z + c with escape and cycle checks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word carries c_re, c_im, start_re, start_im (Q4.28).
//   Master stream: one word per input word; tdata holds the escape depth,
//   tuser bit 0 the escaped flag and bit 1 the in-window flag.
//   Configuration channel: index 0 writes the lower depth bound, index 1
//   the upper one; always ready, other indexes are ignored. Write only
//   while idle.
// Timing:
//   One word at a time; s_tready is high only when the sequencer is idle.
//   Region tests run through the bulb and cardioid states, with extra
//   product states when the cardioid product is needed, then each orbit
//   step reuses the single 32x32 multiplier. Up to 1,000,000 steps.
//   The result sits in an output register; the next word is accepted while
//   it waits, and a finished result holds the sequencer only until the
//   register frees.
// Reset: arst_n clears the sequencer, empties the output register and loads
//   the window registers with 10000 and 100000.
// ----------------------------------------------------------------------------
module mandelbrot_escape_depth_classifier_core import mbedc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // c_re, c_im, start_re, start_im
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // depth, zero pad
	output logic [OUT_TUSER_W-1:0] m_tuser,   // escaped, in_window
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t              cfg;
	res_t              res;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] mul_p;

	// window registers
	mbedc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// shared multiplier
	mbedc_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.prod_s1 (mul_p)
	);

	// sequencer and orbit datapath
	mbedc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.c_re      ($signed(s_tdata[DATA_W-1:0])),
		.c_im      ($signed(s_tdata[2*DATA_W-1:DATA_W])),
		.start_re  ($signed(s_tdata[3*DATA_W-1:2*DATA_W])),
		.start_im  ($signed(s_tdata[4*DATA_W-1:3*DATA_W])),
		.cfg       (cfg),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_p     (mul_p),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// output word packing
	assign m_tdata = OUT_TDATA_W'(res.depth);
	assign m_tuser = {res.in_window, res.escaped};

endmodule

// ===== design/mbedc_mul.sv =====
// ----------------------------------------------------------------------------
// mbedc_mul - shared unsigned multiplier
// One 32x32 product per cycle, registered on the output.
// ----------------------------------------------------------------------------
module mbedc_mul import mbedc_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod_s1
);

	logic [PROD_W-1:0] prod;

	// full product of the magnitudes
	assign prod = PROD_W'(op_a) * PROD_W'(op_b);

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
	end

endmodule

// ===== design/mbedc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mbedc_cfg_regs - depth window registers
// Decodes writes on the configuration channel; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mbedc_cfg_regs import mbedc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_depth <= MIN_DEPTH_RST;
			cfg_q.depth_hi  <= DEPTH_HI_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_DEPTH: cfg_q.min_depth <= cfg_data;
				REG_DEPTH_HI:  cfg_q.depth_hi  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/mbedc_seq.sv =====
// ----------------------------------------------------------------------------
// mbedc_seq - region test and orbit sequencer
// Drives the shared multiplier through the bulb and cardioid tests, then
// runs z = z*z + c with escape and cycle checks, and
// holds the result word for the output channel.
// ----------------------------------------------------------------------------
module mbedc_seq import mbedc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// input words
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] c_re,
	input  logic signed [DATA_W-1:0] c_im,
	input  logic signed [DATA_W-1:0] start_re,
	input  logic signed [DATA_W-1:0] start_im,
	input  cfg_t                     cfg,
	// shared multiplier
	output logic [MUL_W-1:0]         mul_a,
	output logic [MUL_W-1:0]         mul_b,
	input  logic [PROD_W-1:0]        mul_p,
	// result words
	output logic                     out_valid,
	input  logic                     out_ready,
	output res_t                     out_res
);

	localparam int SUM_W  = PROD_W + 1;
	localparam int WIDE_W = PROD_W + 2;
	localparam int ACC_W  = 2 * PROD_W;
	localparam int CARD_SH = 2 * FRAC_BITS - 2;

	localparam logic [Z_W:0]   ONE_M   = (Z_W + 1)'(1) << FRAC_BITS;
	localparam logic [Z_W:0]   TWO_M   = ONE_M << 1;
	localparam logic [Z_W:0]   QUART_M = ONE_M >> 2;
	localparam logic [SUM_W-1:0] BULB_R = SUM_W'(1) << (2 * FRAC_BITS - 4);
	localparam logic [SUM_W-1:0] RAD_R  = SUM_W'(1) << (2 * FRAC_BITS + 2);
	localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(1) << (FRAC_BITS - 1);
	// limit stays below 9, so only offsets of magnitude up to 2 can pass
	localparam logic [4:0] CYC_LIM_N = 5'(CYC_LIMIT);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BULB0 = 4'd1;
	localparam logic [3:0] ST_BULB1 = 4'd2;
	localparam logic [3:0] ST_BULB2 = 4'd3;
	localparam logic [3:0] ST_CARD0 = 4'd4;
	localparam logic [3:0] ST_CARD1 = 4'd5;
	localparam logic [3:0] ST_QMUL  = 4'd6;
	localparam logic [3:0] ST_QCMP  = 4'd7;
	localparam logic [3:0] ST_JUDGE = 4'd8;
	localparam logic [3:0] ST_IT0   = 4'd9;
	localparam logic [3:0] ST_IT1   = 4'd10;
	localparam logic [3:0] ST_IT2   = 4'd11;
	localparam logic [3:0] ST_IT3   = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	function automatic logic [Z_W:0] mag_z(input logic signed [Z_W:0] v);
		logic [Z_W:0] r;
		r = v[Z_W] ? (~v + 1'b1) : v;
		return r;
	endfunction

	logic [3:0] state_q;

	logic signed [DATA_W-1:0] c_re_q, c_im_q;
	logic signed [Z_W-1:0]    zr_q, zi_q, pr_q, pi_q;
	logic [ITER_W-1:0]        i_q, step_q;
	logic [PROD_W-1:0]        sq_q, y2_q, q_q, s_q;
	logic [ACC_W-1:0]         acc_q;
	logic [2:0]               k_q;
	logic signed [PROD_W:0]   diff_q;
	logic bulb_gt_q, bulb_eq_q, card_gt_q, card_eq_q, esc_q;
	logic res_valid_q;
	res_t res_q;

	// point c and its derived offsets
	logic signed [Z_W:0] cr_x, ci_x, b_x, a_x;
	logic [Z_W:0] m_cr, m_ci, m_b, m_a;
	logic in_box;

	assign cr_x = {{(Z_W+1-DATA_W){c_re_q[DATA_W-1]}}, c_re_q};
	assign ci_x = {{(Z_W+1-DATA_W){c_im_q[DATA_W-1]}}, c_im_q};
	assign b_x  = cr_x + $signed(ONE_M);
	assign a_x  = cr_x - $signed(QUART_M);
	assign m_cr = mag_z(cr_x);
	assign m_ci = mag_z(ci_x);
	assign m_b  = mag_z(b_x);
	assign m_a  = mag_z(a_x);
	assign in_box = (m_cr <= ONE_M) && (m_ci <= ONE_M);

	// orbit magnitudes and distance to the snapshot
	logic signed [Z_W:0] zr_x, zi_x, dx_x, dy_x;
	logic [Z_W:0] m_zr, m_zi, m_dx, m_dy;
	logic [3:0] dx2, dy2;
	logic [4:0] d2_sum;
	logic near, z_big;

	assign zr_x = {zr_q[Z_W-1], zr_q};
	assign zi_x = {zi_q[Z_W-1], zi_q};
	assign dx_x = zr_x - $signed({pr_q[Z_W-1], pr_q});
	assign dy_x = zi_x - $signed({pi_q[Z_W-1], pi_q});
	assign m_zr = mag_z(zr_x);
	assign m_zi = mag_z(zi_x);
	assign m_dx = mag_z(dx_x);
	assign m_dy = mag_z(dy_x);
	assign z_big = (m_zr > TWO_M) || (m_zi > TWO_M);
	assign dx2 = {2'b00, m_dx[1:0]} * {2'b00, m_dx[1:0]};
	assign dy2 = {2'b00, m_dy[1:0]} * {2'b00, m_dy[1:0]};
	assign d2_sum = {1'b0, dx2} + {1'b0, dy2};
	assign near = (m_dx[Z_W:2] == '0) && (m_dy[Z_W:2] == '0) && (d2_sum <= CYC_LIM_N);

	// step bookkeeping
	logic i_at_max, past_step, dbl_step;

	assign i_at_max  = (i_q == ITER_W'(MAX_ITER));
	assign past_step = (i_q > step_q);
	assign dbl_step  = ({1'b0, i_q} == {step_q, 1'b0});

	// sum of two squares: bulb and escape radius
	logic [SUM_W-1:0] sq_sum;
	logic rad_out;

	assign sq_sum  = {1'b0, sq_q} + {1'b0, mul_p};
	assign rad_out = (sq_sum > RAD_R);

	// cardioid: s = q + a * one, then q * s against y^2 / 4
	logic signed [WIDE_W-1:0] s_x;
	logic s_pos;
	logic [ACC_W-1:0] card_rhs, pp_ext;
	logic [6:0] pp_sh;

	assign s_x = $signed({2'b00, q_q}) +
		($signed({{(WIDE_W-Z_W-1){a_x[Z_W]}}, a_x}) <<< FRAC_BITS);
	assign s_pos = !s_x[WIDE_W-1] && (s_x != '0);
	assign card_rhs = {{PROD_W{1'b0}}, y2_q} << CARD_SH;

	// partial product placement for the step before the current one
	always_comb begin
		case (k_q) inside
			3'd2, 3'd3: pp_sh = 7'(MUL_W);
			3'd4:       pp_sh = 7'(2 * MUL_W);
			default:    pp_sh = 7'd0;
		endcase
	end
	assign pp_ext = {{PROD_W{1'b0}}, mul_p} << pp_sh;

	// next orbit value, rounded to nearest with ties upward
	logic signed [WIDE_W-1:0] re_sh, im_sh, im_x;
	logic [WIDE_W-1:0] im_mag;
	logic im_sgn;
	logic [Z_W-1:0] nr, ni;

	assign re_sh  = ($signed({diff_q[PROD_W], diff_q}) + HALF_W) >>> FRAC_BITS;
	assign im_mag = {1'b0, mul_p, 1'b0};
	assign im_sgn = zr_q[Z_W-1] ^ zi_q[Z_W-1];
	assign im_x   = im_sgn ? $signed(~im_mag + 1'b1) : $signed(im_mag);
	assign im_sh  = (im_x + HALF_W) >>> FRAC_BITS;
	assign nr = re_sh[Z_W-1:0] + {{(Z_W-DATA_W){c_re_q[DATA_W-1]}}, c_re_q};
	assign ni = im_sh[Z_W-1:0] + {{(Z_W-DATA_W){c_im_q[DATA_W-1]}}, c_im_q};

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_BULB0: begin
				mul_a = m_b[MUL_W-1:0];
				mul_b = m_b[MUL_W-1:0];
			end
			ST_BULB1: begin
				mul_a = m_ci[MUL_W-1:0];
				mul_b = m_ci[MUL_W-1:0];
			end
			ST_BULB2: begin
				mul_a = m_a[MUL_W-1:0];
				mul_b = m_a[MUL_W-1:0];
			end
			ST_QMUL: begin
				mul_a = k_q[1] ? q_q[PROD_W-1:MUL_W] : q_q[MUL_W-1:0];
				mul_b = k_q[0] ? s_q[PROD_W-1:MUL_W] : s_q[MUL_W-1:0];
			end
			ST_IT0: begin
				mul_a = m_zr[MUL_W-1:0];
				mul_b = m_zr[MUL_W-1:0];
			end
			ST_IT1: begin
				mul_a = m_zi[MUL_W-1:0];
				mul_b = m_zi[MUL_W-1:0];
			end
			ST_IT2: begin
				mul_a = m_zr[MUL_W-1:0];
				mul_b = m_zi[MUL_W-1:0];
			end
			default: ;
		endcase
	end

	// result word
	logic [CMP_W-1:0] i_ext;
	logic iterate, out_take;
	res_t res_d;

	assign i_ext   = CMP_W'(i_q);
	assign iterate = (bulb_gt_q || bulb_eq_q) && (card_gt_q || card_eq_q);
	assign out_take = !res_valid_q || out_ready;

	always_comb begin
		res_d.escaped = esc_q;
		if (!esc_q)
			res_d.depth = '0;
		else if (i_ext > CMP_W'({DEPTH_W{1'b1}}))
			res_d.depth = {DEPTH_W{1'b1}};
		else
			res_d.depth = DEPTH_W'(i_ext);
		res_d.in_window = esc_q && bulb_gt_q && card_gt_q &&
			(i_ext >= CMP_W'(cfg.min_depth)) && (i_ext <= CMP_W'(cfg.depth_hi));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_take)
				res_valid_q <= 1'b1;
			else if (out_ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_BULB0;
				ST_BULB0: state_q <= ST_BULB1;
				ST_BULB1: state_q <= ST_BULB2;
				ST_BULB2: state_q <= ST_CARD0;
				ST_CARD0: state_q <= ST_CARD1;
				ST_CARD1: state_q <= (in_box && s_pos) ? ST_QMUL : ST_JUDGE;
				ST_QMUL:  if (k_q == 3'd4) state_q <= ST_QCMP;
				ST_QCMP:  state_q <= ST_JUDGE;
				ST_JUDGE: state_q <= iterate ? ST_IT0 : ST_DONE;
				ST_IT0:   state_q <= (i_at_max || z_big) ? ST_DONE : ST_IT1;
				ST_IT1:   state_q <= ST_IT2;
				ST_IT2:   state_q <= (rad_out || (past_step && near)) ? ST_DONE : ST_IT3;
				ST_IT3:   state_q <= ST_IT0;
				ST_DONE:  if (out_take) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					c_re_q <= c_re;
					c_im_q <= c_im;
					zr_q   <= Z_W'(start_re);
					zi_q   <= Z_W'(start_im);
					pr_q   <= Z_W'(c_re);
					pi_q   <= Z_W'(c_im);
					i_q    <= '0;
					step_q <= ITER_W'(1);
					esc_q  <= 1'b0;
				end
			end
			ST_BULB1: sq_q <= mul_p;
			ST_BULB2: begin
				y2_q      <= mul_p;
				bulb_gt_q <= (sq_sum > BULB_R);
				bulb_eq_q <= (sq_sum == BULB_R);
			end
			ST_CARD0: q_q <= mul_p + y2_q;
			ST_CARD1: begin
				s_q       <= s_x[PROD_W-1:0];
				acc_q     <= '0;
				k_q       <= '0;
				card_gt_q <= !in_box;
				card_eq_q <= in_box && (s_x == '0) && (y2_q == '0);
			end
			ST_QMUL: begin
				if (k_q != 3'd0)
					acc_q <= acc_q + pp_ext;
				k_q <= k_q + 3'd1;
			end
			ST_QCMP: begin
				card_gt_q <= (acc_q > card_rhs);
				card_eq_q <= (acc_q == card_rhs);
			end
			ST_IT0: esc_q <= !i_at_max && z_big;
			ST_IT1: sq_q <= mul_p;
			ST_IT2: begin
				esc_q  <= rad_out;
				diff_q <= $signed({1'b0, sq_q}) - $signed({1'b0, mul_p});
				if (!rad_out && past_step && dbl_step) begin
					step_q <= step_q << 1;
					pr_q   <= zr_q;
					pi_q   <= zi_q;
				end
			end
			ST_IT3: begin
				zr_q <= $signed(nr);
				zi_q <= $signed(ni);
				i_q  <= i_q + 1'b1;
			end
			ST_DONE: if (out_take) res_q <= res_d;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = res_valid_q;
	assign out_res   = res_q;

endmodule

// ===== design/mbedc_checker.sv =====
// ----------------------------------------------------------------------------
// mbedc_checker - port-level checks of the classifier
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module mbedc_checker import mbedc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser
);

	// one word in flight: a taken word closes the input side
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after a word was taken");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// in-window needs an escape
	a_window_escaped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[0] || !m_tuser[1])
		else $error("in-window flag on a bounded point");

	// bounded points carry zero depth
	a_bounded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("bounded point with non-zero depth");

endmodule

bind mandelbrot_escape_depth_classifier_core mbedc_checker u_mbedc_checker (.*);

// ===== verif/mandelbrot_escape_depth_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_depth_classifier_core_tb - escape-depth classifier bench
// Streams points c with start values z into the core and checks every result
// word against an orbit predictor kept inside the bench. Phases change the
// depth window between runs of points. Random mixes hold full-range noise,
// points in the plane near the set and points close to the cusp and the
// necks; one phase adds directed corner cases. Both stream sides idle in
// short random bursts, and one long output stall backs the core up.
// ----------------------------------------------------------------------------
module mandelbrot_escape_depth_classifier_core_tb;
	import mbedc_pkg::*;

	// orbit arithmetic
	localparam longint FX_ONE     = longint'(1) << FRAC_BITS;
	localparam longint FX_HALF    = FX_ONE >>> 1;
	localparam longint FX_QUARTER = FX_ONE >>> 2;
	localparam longint NEAR_SQ_LIMIT =
		longint'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10000000000000000);
	localparam real    FX_SCALE   = 2.0 ** FRAC_BITS;

	// window registers after reset
	localparam logic [CFG_W-1:0] WIN_LO_RESET = CFG_W'(10000);
	localparam logic [CFG_W-1:0] WIN_HI_RESET = CFG_W'(100000);
	localparam logic [CFG_W-1:0] DEPTH_TOP    = {CFG_W{1'b1}};
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(2);

	// step budgets that keep the run short
	localparam int unsigned RAND_CAP   = 3000;
	localparam int unsigned DIRECT_CAP = 20000;

	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int TAIL_CYCLES   = 200;

	typedef struct {
		logic [31:0] c_re;
		logic [31:0] c_im;
		logic [31:0] start_re;
		logic [31:0] start_im;
	} point_t;

	typedef struct {
		bit               esc;
		bit [DEPTH_W-1:0] depth;
		bit               win;
		bit               capped;
	} verdict_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;

	point_t   points_pending[$];
	verdict_t verdicts_due[$];

	logic [CFG_W-1:0] win_lo = WIN_LO_RESET;
	logic [CFG_W-1:0] win_hi = WIN_HI_RESET;

	bit idle_on  = 1'b1;
	bit in_taken = 1'b0;
	int gap_left = 0;
	int rx_hold  = 0;
	int hold_req  = 0;
	int hold_seen = 0;
	int words_issued  = 0;
	int words_checked = 0;
	int mismatches    = 0;

	mandelbrot_escape_depth_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // c_re, c_im, start_re, start_im
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // depth, zero pad
		.m_tuser   (m_tuser),   // escaped, in_window
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// hard stop
	initial begin
		#100_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [31:0] fx(real r);
		return 32'($rtoi(r * FX_SCALE));
	endfunction

	function automatic point_t mk(logic [31:0] cr, logic [31:0] ci,
			logic [31:0] zr, logic [31:0] zi);
		point_t p;
		p.c_re = cr;
		p.c_im = ci;
		p.start_re = zr;
		p.start_im = zi;
		return p;
	endfunction

	// sign of (x+1)^2 + y^2 - 1/16
	function automatic int bulb_side(longint x, longint y);
		longint b;
		longint unsigned d;
		longint unsigned r;
		b = x + FX_ONE;
		d = longint'(b * b) + longint'(y * y);
		r = longint'(1) << (2 * FRAC_BITS - 4);
		return (d < r) ? -1 : ((d > r) ? 1 : 0);
	endfunction

	// sign of q*(q + x - 1/4) - y^2/4, q = (x-1/4)^2 + y^2
	function automatic int cardioid_side(longint x, longint y);
		longint a;
		longint q;
		longint s;
		logic [127:0] lhs;
		logic [127:0] rhs;
		if (mag(x) > FX_ONE || mag(y) > FX_ONE)
			return 1;
		a = x - FX_QUARTER;
		q = a * a + y * y;
		s = q + a * FX_ONE;
		if (s < 0)
			return -1;
		lhs = {64'd0, q} * {64'd0, s};
		rhs = {64'd0, y * y} << (2 * FRAC_BITS - 2);
		return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
	endfunction

	function automatic bit beyond_radius(longint re, longint im);
		longint unsigned m;
		if (mag(re) > 2 * FX_ONE || mag(im) > 2 * FX_ONE)
			return 1'b1;
		m = longint'(re * re) + longint'(im * im);
		return m > (64'd4 << (2 * FRAC_BITS));
	endfunction

	// escape-depth verdict of one point; stops early after cap steps
	function automatic verdict_t classify_point(point_t p, logic [CFG_W-1:0] lo,
			logic [CFG_W-1:0] hi, int unsigned cap);
		longint cr, ci, zr, zi, pr, pi, nr, ni, dx, dy;
		int bc, cc;
		bit outside, esc, stopped;
		int unsigned i, span, lim;
		verdict_t v;
		cr = longint'(signed'(p.c_re));
		ci = longint'(signed'(p.c_im));
		zr = longint'(signed'(p.start_re));
		zi = longint'(signed'(p.start_im));
		pr = cr;
		pi = ci;
		bc = bulb_side(cr, ci);
		cc = cardioid_side(cr, ci);
		outside = (bc > 0) && (cc > 0);
		esc = 1'b0;
		stopped = 1'b0;
		span = 1;
		i = 0;
		lim = (cap < MAX_ITER) ? cap : MAX_ITER;
		v.capped = 1'b0;
		if (bc >= 0 && cc >= 0) begin
			for (i = 0; i < lim; i++) begin
				if (beyond_radius(zr, zi)) begin
					esc = 1'b1;
					stopped = 1'b1;
					break;
				end
				// periodicity: compare against a snapshot retaken at doubling counts
				if (i > span) begin
					dx = zr - pr;
					dy = zi - pi;
					if (mag(dx) < 65536 && mag(dy) < 65536 &&
							dx * dx + dy * dy <= NEAR_SQ_LIMIT) begin
						stopped = 1'b1;
						break;
					end
					if (i == 2 * span) begin
						span = span * 2;
						pr = zr;
						pi = zi;
					end
				end
				nr = ((zr * zr - zi * zi + FX_HALF) >>> FRAC_BITS) + cr;
				ni = ((2 * zr * zi + FX_HALF) >>> FRAC_BITS) + ci;
				zr = nr;
				zi = ni;
			end
			v.capped = !stopped && (lim < MAX_ITER);
		end
		v.esc = esc;
		v.depth = !esc ? '0 : ((i > DEPTH_TOP) ? DEPTH_TOP : i[DEPTH_W-1:0]);
		v.win = esc && outside && (i >= lo) && (i <= hi);
		return v;
	endfunction

	// queue a point unless its orbit runs past the step budget
	function automatic bit queue_point(point_t p, int unsigned cap);
		verdict_t v;
		v = classify_point(p, win_lo, win_hi, cap);
		if (v.capped)
			return 1'b0;
		points_pending.push_back(p);
		return 1'b1;
	endfunction

	task automatic queue_random(int n);
		point_t p;
		int added;
		int kind;
		logic [31:0] br;
		logic [31:0] bi;
		added = 0;
		while (added < n) begin
			kind = $urandom_range(19);
			p.start_re = '0;
			p.start_im = '0;
			if (kind < 3) begin
				// full-range noise on every field
				p.c_re = $urandom;
				p.c_im = $urandom;
				p.start_re = $urandom;
				p.start_im = $urandom;
			end else if (kind < 12) begin
				// plane around the set, z from zero
				p.c_re = fx(-2.1) + $urandom_range(fx(2.7));
				p.c_im = fx(-1.3) + $urandom_range(fx(2.6));
			end else if (kind < 16) begin
				// close to the cusp, the necks and the tip: deeper escapes
				case ($urandom_range(3))
					0: begin
						br = fx(0.25);
						bi = fx(0.0);
					end
					1: begin
						br = fx(-0.75);
						bi = fx(0.0);
					end
					2: begin
						br = fx(-1.25);
						bi = fx(0.0);
					end
					default: begin
						br = fx(-2.0);
						bi = fx(0.0);
					end
				endcase
				p.c_re = br + $urandom_range(32'h003F_FFFF) - 32'h0020_0000;
				p.c_im = bi + $urandom_range(32'h003F_FFFF) - 32'h0020_0000;
			end else begin
				// plane point with a start z inside radius 2 or so
				p.c_re = fx(-2.1) + $urandom_range(fx(2.7));
				p.c_im = fx(-1.3) + $urandom_range(fx(2.6));
				p.start_re = fx(-2.0) + $urandom_range(fx(4.0));
				p.start_im = fx(-2.0) + $urandom_range(fx(4.0));
			end
			if (queue_point(p, RAND_CAP))
				added++;
		end
	endtask

	task automatic queue_directed();
		// rejected by the main cardioid and by the period-2 bulb
		void'(queue_point(mk(fx(0.0), fx(0.0), fx(0.0), fx(0.0)), DIRECT_CAP));
		void'(queue_point(mk(fx(-1.0), fx(0.0), fx(0.0), fx(0.0)), DIRECT_CAP));
		// rejection wins even with a start far outside radius 2
		void'(queue_point(mk(fx(0.0), fx(0.0), 32'h7FFF_FFFF, 32'h8000_0000),
			DIRECT_CAP));
		// extreme c values
		void'(queue_point(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, fx(0.0), fx(0.0)),
			DIRECT_CAP));
		void'(queue_point(mk(32'h8000_0000, 32'h8000_0000, fx(0.0), fx(0.0)),
			DIRECT_CAP));
		void'(queue_point(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
			DIRECT_CAP));
		// start already outside: depth zero
		void'(queue_point(mk(fx(2.0), fx(0.0), fx(3.0), fx(0.0)), DIRECT_CAP));
		void'(queue_point(mk(fx(0.0), fx(-1.0), fx(1.5), fx(1.5)), DIRECT_CAP));
		// on the cusp of the cardioid: iterated but never in window
		void'(queue_point(mk(fx(0.25), fx(0.0), fx(3.0), fx(0.0)), DIRECT_CAP));
		// on the bulb edge with z exactly on radius 2
		void'(queue_point(mk(fx(-1.25), fx(0.0), fx(2.0), fx(0.0)), DIRECT_CAP));
		// on both edges where bulb and cardioid touch, then on the bulb edge alone
		void'(queue_point(mk(fx(-0.75), fx(0.0), fx(-3.0), fx(0.0)), DIRECT_CAP));
		void'(queue_point(mk(fx(-1.0), fx(0.25), fx(0.0), fx(2.5)), DIRECT_CAP));
		// tip of the set: orbit sits on radius 2, caught by the cycle check
		void'(queue_point(mk(fx(-2.0), fx(0.0), fx(0.0), fx(0.0)), DIRECT_CAP));
		// preperiodic orbit of c = i
		void'(queue_point(mk(fx(0.0), fx(1.0), fx(0.0), fx(0.0)), DIRECT_CAP));
		// period-3 bulb centre
		void'(queue_point(mk(fx(-0.1225), fx(0.7449), fx(0.0), fx(0.0)), DIRECT_CAP));
		// slow escapes past the cusp and through the neck
		void'(queue_point(mk(fx(0.3), fx(0.0), fx(0.0), fx(0.0)), DIRECT_CAP));
		void'(queue_point(mk(fx(0.26), fx(0.0), fx(0.0), fx(0.0)), DIRECT_CAP));
		void'(queue_point(mk(fx(0.25) + 32'd1024, fx(0.0), fx(0.0), fx(0.0)),
			DIRECT_CAP));
		void'(queue_point(mk(fx(-0.75), fx(0.1), fx(0.0), fx(0.0)), DIRECT_CAP));
		void'(queue_point(mk(fx(0.3), fx(0.0), fx(0.1), fx(-0.1)), DIRECT_CAP));
		void'(queue_point(mk(fx(0.4), fx(-0.3), fx(0.0), fx(0.0)), DIRECT_CAP));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every issued word has its result, then let the core settle
	task automatic drain();
		while (points_pending.size() != 0 || words_issued != words_checked)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic flag_mismatch(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// input driver: next point at the falling edge once the last was taken
	always @(negedge clk) begin
		point_t nxt;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (points_pending.size() != 0) begin
					nxt = points_pending.pop_front();
					words_issued++;
					s_tdata  <= {nxt.start_im, nxt.start_re, nxt.c_im, nxt.c_re};
					s_tvalid <= 1'b1;
					if (idle_on && $urandom_range(3) == 0)
						gap_left = $urandom_range(10, 1);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: random stall bursts plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rx_hold = LONG_HOLD;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(5) == 0) begin
				rx_hold = $urandom_range(9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: register writes, accepted points and result words
	always @(posedge clk) begin
		point_t got;
		verdict_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_DEPTH: win_lo = cfg_data;
					REG_DEPTH_HI:  win_hi = cfg_data;
					default: ;
				endcase
			end
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				got.c_re     = s_tdata[31:0];
				got.c_im     = s_tdata[63:32];
				got.start_re = s_tdata[95:64];
				got.start_im = s_tdata[127:96];
				verdicts_due.push_back(classify_point(got, win_lo, win_hi, MAX_ITER));
			end
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					flag_mismatch("result word with nothing expected");
				end else begin
					want = verdicts_due.pop_front();
					words_checked++;
					if (m_tuser[0] !== want.esc)
						flag_mismatch($sformatf("word %0d escaped %b, want %b",
							words_checked, m_tuser[0], want.esc));
					if (m_tdata[DEPTH_W-1:0] !== want.depth)
						flag_mismatch($sformatf("word %0d depth %0d, want %0d",
							words_checked, m_tdata[DEPTH_W-1:0], want.depth));
					if (m_tuser[1] !== want.win)
						flag_mismatch($sformatf("word %0d in_window %b, want %b",
							words_checked, m_tuser[1], want.win));
				end
			end
		end
	end

	// sequence of phases
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// window as after reset
		queue_random(12);
		drain();

		// widest window, corner cases
		write_reg(REG_MIN_DEPTH, '0);
		write_reg(REG_DEPTH_HI, DEPTH_TOP);
		queue_directed();
		queue_random(18);
		drain();

		// narrow window; the output side holds off long enough to back up the core
		write_reg(REG_MIN_DEPTH, CFG_W'(5));
		write_reg(REG_DEPTH_HI, CFG_W'(60));
		queue_random(22);
		hold_req++;
		drain();

		// empty window; a write to an unmapped index must change nothing
		write_reg(REG_UNMAPPED, CFG_W'(20'h00ABC));
		write_reg(REG_MIN_DEPTH, DEPTH_TOP);
		write_reg(REG_DEPTH_HI, '0);
		queue_random(14);
		drain();

		// last stretch at full rate
		write_reg(REG_MIN_DEPTH, CFG_W'(3));
		write_reg(REG_DEPTH_HI, CFG_W'(300));
		idle_on = 1'b0;
		queue_random(22);
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
